/* src/qdd_pkg.sv */
// Shared types, constants and the Gray-code step lookup for the quadrature detent decoder.
// No dependencies.
`default_nettype none
package qdd_pkg;

  localparam int unsigned TS_W = 32;
  localparam int unsigned CFG_W = 8;

  localparam logic OP_POLL = 1'b0;
  localparam logic OP_INIT = 1'b1;

  localparam logic [CFG_W-1:0] MIN_INTERVAL_RESET = 8'd2;

  // accumulator after adding one step spans -4..4
  localparam logic signed [3:0] DETENT_POS = 4'sd4;
  localparam logic signed [3:0] DETENT_NEG = -4'sd4;

  localparam logic signed [1:0] STEP_NONE = 2'sd0;
  localparam logic signed [1:0] STEP_FWD = 2'sd1;
  localparam logic signed [1:0] STEP_REV = -2'sd1;

  typedef struct packed {
    logic            op;
    logic [1:0]      ab;      // A in bit 1, B in bit 0
    logic [TS_W-1:0] now_ms;
  } qdd_item_t;

  typedef struct packed {
    logic            turn_ccw;
    logic [TS_W-1:0] velocity_ms;
  } qdd_result_t;

  // index is {previous AB, new AB}
  function automatic logic signed [1:0] gray_step(input logic [3:0] idx);
    logic signed [1:0] s;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_FWD;
      4'd2, 4'd4, 4'd11, 4'd13: s = STEP_REV;
      default:                  s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* src/qdd_in_stage.sv */
// Input register for sample beats; holds one item for the decode logic.
// Depends on qdd_pkg.
`default_nettype none
module qdd_in_stage
  import qdd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire qdd_item_t in_item,
  input  wire logic      take,
  output logic           item_valid,
  output qdd_item_t      item
);

  logic      valid_r;
  qdd_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

/* src/qdd_core.sv */
// Decoder state and single-pass update: transition lookup, interval gate, tick ring, detent.
// Depends on qdd_pkg.
`default_nettype none
module qdd_core
  import qdd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             item_valid,
  input  wire qdd_item_t        item,
  input  wire logic             slot_free,
  output logic                  take,
  output logic                  res_valid,
  output qdd_result_t           result
);

  localparam int unsigned HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [HW-1:0] HEAD_LAST = HW'(HISTORY_DEPTH - 1);

  logic [CFG_W-1:0]        min_r;
  logic [1:0]              prev_ab_r;
  logic signed [2:0]       accum_r;
  logic [HW-1:0]           head_r;
  logic [TS_W-1:0]         last_r;
  logic [TS_W-1:0]         times_r [HISTORY_DEPTH];

  logic                    is_init;
  logic                    changed;
  logic signed [1:0]       step;
  logic [TS_W-1:0]         elapsed;
  logic                    accept;
  logic signed [3:0]       sum;
  logic                    detent;
  logic [HW-1:0]           head_nxt;
  logic                    fire;

  assign is_init  = (item.op == OP_INIT);
  assign changed  = (item.ab != prev_ab_r);
  assign step     = gray_step({prev_ab_r, item.ab});
  assign elapsed  = item.now_ms - last_r;
  assign accept   = !is_init && changed && (step != STEP_NONE)
                    && !(elapsed < {{(TS_W-CFG_W){1'b0}}, min_r});
  assign sum      = {accum_r[2], accum_r} + {{2{step[1]}}, step};
  assign detent   = accept && ((sum == DETENT_POS) || (sum == DETENT_NEG));
  assign head_nxt = (head_r == HEAD_LAST) ? '0 : head_r + 1'b1;

  assign take      = item_valid && (!detent || slot_free);
  assign fire      = take;
  assign res_valid = fire && detent;

  assign result.turn_ccw    = sum[3];
  assign result.velocity_ms = item.now_ms - times_r[head_nxt];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_INTERVAL_RESET;
    end else if (cfg_we) begin
      min_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ab_r <= '0;
      accum_r   <= '0;
      head_r    <= '0;
      last_r    <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) times_r[i] <= '0;
    end else if (fire) begin
      if (is_init) begin
        prev_ab_r <= item.ab;
        accum_r   <= '0;
        head_r    <= '0;
        last_r    <= item.now_ms;
        for (int i = 0; i < HISTORY_DEPTH; i++) times_r[i] <= item.now_ms;
      end else if (changed) begin
        prev_ab_r <= item.ab;
        if (accept) begin
          last_r          <= item.now_ms;
          times_r[head_r] <= item.now_ms;
          head_r          <= head_nxt;
          accum_r         <= detent ? 3'sd0 : sum[2:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

/* src/qdd_out_stage.sv */
// Result register for detent beats; frees the decode stage while a result waits.
// Depends on qdd_pkg.
`default_nettype none
module qdd_out_stage
  import qdd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        res_valid,
  input  wire qdd_result_t result,
  output logic             slot_free,
  output logic             out_valid,
  input  wire logic        out_ready,
  output qdd_result_t      out_result
);

  logic        valid_r;
  qdd_result_t result_r;

  assign slot_free  = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      result_r <= result;
    end
  end

endmodule
`default_nettype wire

/* src/quadrature_detent_decoder_top.sv */
// Top level of the quadrature detent decoder: stream ports, input stage, core, result stage.
// Depends on qdd_pkg, qdd_in_stage, qdd_core, qdd_out_stage.
//
//   channel | dir | handshake            | payload
//   in      | in  | in_tvalid/in_tready  | in_tdata, in_tuser
//   out     | out | out_tvalid/out_tready| out_tdata
//   cfg     | in  | cfg_we               | cfg_wdata (min_interval_ms)
//
// One beat per cycle sustained while no detent waits on a full result register; a result
// is registered in the result stage after the single decode pass between the two registers.
// Synchronous active-low reset clears state; min interval resets to 2 ms.
// A detent waits in the decode stage only while the result register is full
// and not taken; non-detent samples pass regardless.
`default_nettype none
module quadrature_detent_decoder_top
  import qdd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [39:0]      in_tdata,   // a_level, b_level, now_ms[31:0], zero pad
  input  wire logic [0:0]       in_tuser,   // op
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [39:0]           out_tdata   // turn_ccw, velocity_ms[31:0], zero pad
);

  qdd_item_t   in_item;
  qdd_item_t   item;
  logic        item_valid;
  logic        take;
  logic        res_valid;
  logic        slot_free;
  qdd_result_t result;
  qdd_result_t out_result;

  assign in_item.op     = in_tuser[0];
  assign in_item.ab     = {in_tdata[0], in_tdata[1]};
  assign in_item.now_ms = in_tdata[33:2];

  assign out_tdata = {7'd0, out_result.velocity_ms, out_result.turn_ccw};

  qdd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  qdd_core #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .slot_free  (slot_free),
    .take       (take),
    .res_valid  (res_valid),
    .result     (result)
  );

  qdd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .result     (result),
    .slot_free  (slot_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

endmodule
`default_nettype wire
